// File: src/gtt_pkg.sv
// Shared types, codes and helpers for the gauge target trigger.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gtt_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int GAUGE_COUNT_DEF   = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SUM_W      = 48;
    localparam int LIMIT_W    = 47;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_EPS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_EXPAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CONTRACT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVEMENT_EPS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MS         = 3'd7;

    localparam logic [15:0] WAIT_MS_RESET = 16'd1000;

    // Action codes.
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_NEXT   = 2'd1;
    localparam logic [1:0] ACT_PREV   = 2'd2;
    localparam logic [1:0] ACT_LOAD   = 2'd3;

    // Direction codes.
    localparam logic [1:0] DIR_STABLE   = 2'd0;
    localparam logic [1:0] DIR_EXPAND   = 2'd1;
    localparam logic [1:0] DIR_CONTRACT = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] sample;
        logic [31:0]        now_ms;
        logic [2:0]         entry_index;
        logic signed [31:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic               trigger;
        logic [1:0]         direction;
        logic signed [31:0] display_value;
        logic signed [31:0] target;
        logic [2:0]         gauge_index;
    } out_item_t;

    // Classified item as it waits between the front and the back.
    typedef struct packed {
        in_item_t    item;
        logic        dir_up;
        logic        dir_down;
        logic        moved;
        logic [32:0] adelta;
    } q_item_t;

    typedef struct packed {
        logic               auto_mode;
        logic [30:0]        direction_eps;
        logic signed [31:0] offset_expand;
        logic signed [31:0] offset_contract;
        logic [30:0]        tolerance;
        logic [30:0]        release_limit;
        logic [30:0]        movement_eps;
        logic [15:0]        wait_ms;
        logic [LIMIT_W-1:0] move_limit;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/gauge_target_trigger.sv
// Gauge target trigger: position samples in, one trigger and display result
// out per item. Top level; depends on gtt_pkg, gtt_front, gtt_queue, gtt_back.
//
// Items arrive on the s_ channel (valid/ready) and carry an action: a
// position sample, a gauge step up or down, or a gauge table load. Every
// accepted item gives exactly one result on the m_ channel, in order.
// Each result is registered first in the two-entry queue and then in the
// output register, and one item a cycle is taken for as long as results are
// drained; the back stage updates the held direction, the trigger arm and
// the movement window for each item as it pops that item from the queue.
// When m_ready is low the output register holds its result, the two-entry
// queue fills, and s_ready falls once the queue is full.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata, by the
// user only while no item is in flight (the block does not enforce this); the
// movement limit is registered from the stored settings. Synchronous reset clears
// the history ring, gauge table and control state; s_ready is high after reset.
`default_nettype none

module gauge_target_trigger #(
    parameter int HISTORY_DEPTH = gtt_pkg::HISTORY_DEPTH_DEF,
    parameter int GAUGE_COUNT   = gtt_pkg::GAUGE_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gtt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire gtt_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output gtt_pkg::out_item_t                  m_data
);

    gtt_pkg::cfg_t    cfg_reg, cfg_next;
    gtt_pkg::q_item_t front_item;
    gtt_pkg::q_item_t queue_item;
    logic             queue_full;
    logic             queue_valid;
    logic             queue_pop;
    logic             push;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                gtt_pkg::CFG_AUTO_MODE:       cfg_next.auto_mode       = cfg_wdata[0];
                gtt_pkg::CFG_DIRECTION_EPS:   cfg_next.direction_eps   = cfg_wdata[30:0];
                gtt_pkg::CFG_OFFSET_EXPAND:   cfg_next.offset_expand   = cfg_wdata;
                gtt_pkg::CFG_OFFSET_CONTRACT: cfg_next.offset_contract = cfg_wdata;
                gtt_pkg::CFG_TOLERANCE:       cfg_next.tolerance       = cfg_wdata[30:0];
                gtt_pkg::CFG_RELEASE_LIMIT:   cfg_next.release_limit   = cfg_wdata[30:0];
                gtt_pkg::CFG_MOVEMENT_EPS:    cfg_next.movement_eps    = cfg_wdata[30:0];
                gtt_pkg::CFG_WAIT_MS:         cfg_next.wait_ms         = cfg_wdata[15:0];
                default: ;
            endcase
        end
        // Movement threshold over the whole window, kept as a registered product.
        cfg_next.move_limit = {16'b0, cfg_reg.movement_eps} * {31'b0, cfg_reg.wait_ms};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_mode       <= 1'b1;
            cfg_reg.direction_eps   <= '0;
            cfg_reg.offset_expand   <= '0;
            cfg_reg.offset_contract <= '0;
            cfg_reg.tolerance       <= '0;
            cfg_reg.release_limit   <= '0;
            cfg_reg.movement_eps    <= '0;
            cfg_reg.wait_ms         <= gtt_pkg::WAIT_MS_RESET;
            cfg_reg.move_limit      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gtt_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_item (s_data),
        .push    (push),
        .q_item  (front_item)
    );

    gtt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_data   (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .rd_data   (queue_item),
        .not_empty (queue_valid)
    );

    gtt_back #(
        .GAUGE_COUNT (GAUGE_COUNT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (queue_valid),
        .q_item  (queue_item),
        .pop     (queue_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: src/gtt_front.sv
// Front stage: keeps the sample history ring and classifies each accepted item.
// Depends on gtt_pkg.
`default_nettype none

module gtt_front #(
    parameter int HISTORY_DEPTH = gtt_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gtt_pkg::cfg_t     cfg,
    input  wire gtt_pkg::in_item_t in_item,
    input  wire logic              push,
    output gtt_pkg::q_item_t       q_item
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    logic signed [31:0] ring_reg [HISTORY_DEPTH];
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   old_ptr;
    logic signed [31:0] old_val;
    logic signed [32:0] s_ext;
    logic signed [32:0] old_ext;
    logic signed [32:0] delta;
    logic signed [32:0] neg_delta;
    logic signed [33:0] eps_ext;
    logic [32:0]        adelta;
    logic               is_sample;

    always_comb begin
        is_sample = (in_item.action == gtt_pkg::ACT_SAMPLE);
        old_ptr   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
        // With a one-entry history the oldest sample is the one just written.
        old_val   = (old_ptr == ptr_reg) ? in_item.sample : ring_reg[old_ptr];
        s_ext     = {in_item.sample[31], in_item.sample};
        old_ext   = {old_val[31], old_val};
        delta     = s_ext - old_ext;
        neg_delta = old_ext - s_ext;
        eps_ext   = {3'b000, cfg.direction_eps};
        adelta    = delta[32] ? neg_delta : delta;

        q_item          = '0;
        q_item.item     = in_item;
        q_item.dir_up   = is_sample && ($signed({delta[32], delta}) > eps_ext);
        q_item.dir_down = is_sample && ($signed({neg_delta[32], neg_delta}) > eps_ext);
        q_item.moved    = is_sample && (adelta > {2'b00, cfg.movement_eps});
        q_item.adelta   = adelta;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (push && is_sample) begin
            ring_reg[ptr_reg] <= in_item.sample;
            ptr_reg           <= old_ptr;
        end
    end

endmodule

`default_nettype wire

// File: src/gtt_queue.sv
// Two-entry queue that decouples the classifying front from the back.
// Depends on gtt_pkg.
`default_nettype none

module gtt_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire gtt_pkg::q_item_t wr_data,
    output logic                  full,
    input  wire logic             pop,
    output gtt_pkg::q_item_t      rd_data,
    output logic                  not_empty
);

    localparam int PTR_W = (gtt_pkg::QUEUE_DEPTH > 1) ? $clog2(gtt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gtt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(gtt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(gtt_pkg::QUEUE_DEPTH);

    gtt_pkg::q_item_t mem_reg [gtt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/gtt_back.sv
// Back stage: direction, target, trigger, timed window and gauge selection,
// with the registered result output. Depends on gtt_pkg.
`default_nettype none

module gtt_back #(
    parameter int GAUGE_COUNT = gtt_pkg::GAUGE_COUNT_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire gtt_pkg::cfg_t    cfg,
    input  wire logic             q_valid,
    input  wire gtt_pkg::q_item_t q_item,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output gtt_pkg::out_item_t    m_data
);

    localparam int GI_W = (GAUGE_COUNT > 1) ? $clog2(GAUGE_COUNT) : 1;
    localparam logic [2:0] G_LAST  = 3'(GAUGE_COUNT - 1);
    localparam logic [3:0] G_COUNT = 4'(GAUGE_COUNT);

    function automatic logic in_band(input logic signed [32:0] e, input logic [30:0] lim);
        logic signed [33:0] ew;
        logic signed [33:0] lw;
        ew = {e[32], e};
        lw = {3'b000, lim};
        return (ew <= lw) && (ew >= -lw);
    endfunction

    logic signed [31:0]   table_reg [GAUGE_COUNT];
    logic [2:0]           sel_reg, sel_next;
    logic signed [31:0]   cur_reg, cur_next;
    logic [1:0]           dir_reg, dir_next;
    logic                 armed_reg, armed_next;
    logic                 win_reg, win_next;
    logic [31:0]          wstart_reg, wstart_next;
    logic [gtt_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0]   tgt_st_reg, tgt_exp_reg, tgt_con_reg;
    logic signed [31:0]   tgt_st_next, tgt_exp_next, tgt_con_next;
    gtt_pkg::out_item_t   out_reg;
    logic                 out_valid_reg;

    logic                 is_sample;
    logic                 wr_en;
    logic signed [31:0]   g_val;
    logic signed [31:0]   s;
    logic signed [32:0]   err_st, err_exp, err_con;
    logic                 in_tol, out_rel;
    logic                 trig;
    logic                 starting, active_mid, closing, elapsed_ok;
    logic [gtt_pkg::SUM_W-1:0] sum_base;
    logic [gtt_pkg::SUM_W:0]   sum_raw;
    logic [32:0]          add;
    logic [31:0]          elapsed;
    logic signed [31:0]   disp, tgt_out;

    assign pop     = q_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        is_sample = pop && (q_item.item.action == gtt_pkg::ACT_SAMPLE);
        s         = q_item.item.sample;

        // Gauge selection and table load.
        sel_next = sel_reg;
        if (pop && q_item.item.action == gtt_pkg::ACT_NEXT) begin
            sel_next = (sel_reg < G_LAST) ? sel_reg + 3'd1 : G_LAST;
        end else if (pop && q_item.item.action == gtt_pkg::ACT_PREV) begin
            sel_next = (sel_reg != 3'd0) ? sel_reg - 3'd1 : sel_reg;
        end
        wr_en = pop && (q_item.item.action == gtt_pkg::ACT_LOAD)
                && ({1'b0, q_item.item.entry_index} < G_COUNT);
        g_val = (wr_en && q_item.item.entry_index == sel_next) ? q_item.item.entry_value
                                                               : table_reg[sel_next[GI_W-1:0]];

        // Target candidates for each direction, kept ready for the next item.
        tgt_st_next  = g_val;
        tgt_exp_next = gtt_pkg::sat32({g_val[31], g_val} +
                                      {cfg.offset_expand[31], cfg.offset_expand});
        tgt_con_next = gtt_pkg::sat32({g_val[31], g_val} +
                                      {cfg.offset_contract[31], cfg.offset_contract});

        dir_next = dir_reg;
        if (is_sample && q_item.dir_up) begin
            dir_next = gtt_pkg::DIR_EXPAND;
        end else if (is_sample && q_item.dir_down) begin
            dir_next = gtt_pkg::DIR_CONTRACT;
        end
        cur_next = is_sample ? s : cur_reg;

        // Errors against all three candidates in parallel; the direction picks one.
        err_st  = {s[31], s} - {tgt_st_reg[31], tgt_st_reg};
        err_exp = {s[31], s} - {tgt_exp_reg[31], tgt_exp_reg};
        err_con = {s[31], s} - {tgt_con_reg[31], tgt_con_reg};
        case (dir_next)
            gtt_pkg::DIR_EXPAND: begin
                in_tol  = in_band(err_exp, cfg.tolerance);
                out_rel = !in_band(err_exp, cfg.release_limit);
                disp    = gtt_pkg::sat32({cur_next[31], cur_next} -
                                         {cfg.offset_expand[31], cfg.offset_expand});
                tgt_out = tgt_exp_next;
            end
            gtt_pkg::DIR_CONTRACT: begin
                in_tol  = in_band(err_con, cfg.tolerance);
                out_rel = !in_band(err_con, cfg.release_limit);
                disp    = gtt_pkg::sat32({cur_next[31], cur_next} -
                                         {cfg.offset_contract[31], cfg.offset_contract});
                tgt_out = tgt_con_next;
            end
            default: begin
                in_tol  = in_band(err_st, cfg.tolerance);
                out_rel = !in_band(err_st, cfg.release_limit);
                disp    = cur_next;
                tgt_out = tgt_st_next;
            end
        endcase

        // Timed movement window.
        starting   = (dir_next == gtt_pkg::DIR_EXPAND) && !win_reg;
        active_mid = win_reg || starting;
        sum_base   = starting ? '0 : sum_reg;
        add        = q_item.moved ? q_item.adelta : '0;
        sum_raw    = {1'b0, sum_base} + {16'b0, add};
        elapsed    = q_item.item.now_ms - wstart_reg;
        elapsed_ok = starting ? (cfg.wait_ms == 16'd0) : (elapsed >= {16'b0, cfg.wait_ms});
        closing    = active_mid && elapsed_ok;

        armed_next  = armed_reg;
        win_next    = win_reg;
        wstart_next = wstart_reg;
        sum_next    = sum_reg;
        trig        = 1'b0;
        if (is_sample && cfg.auto_mode) begin
            armed_next  = (armed_reg || in_tol) && !out_rel;
            win_next    = active_mid && !closing;
            wstart_next = starting ? q_item.item.now_ms : wstart_reg;
            // The limit stays below the saturated sum, so the unsaturated sum compares alike.
            sum_next    = sum_raw[gtt_pkg::SUM_W] ? '1 : sum_raw[gtt_pkg::SUM_W-1:0];
            trig        = (!armed_reg && in_tol) ||
                          (closing && ({1'b0, sum_raw} > {3'b000, cfg.move_limit}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg       <= '0;
            cur_reg       <= '0;
            dir_reg       <= gtt_pkg::DIR_STABLE;
            armed_reg     <= 1'b0;
            win_reg       <= 1'b0;
            wstart_reg    <= '0;
            sum_reg       <= '0;
            tgt_st_reg    <= '0;
            tgt_exp_reg   <= '0;
            tgt_con_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GAUGE_COUNT; i++) begin
                table_reg[i] <= '0;
            end
        end else begin
            sel_reg     <= sel_next;
            cur_reg     <= cur_next;
            dir_reg     <= dir_next;
            armed_reg   <= armed_next;
            win_reg     <= win_next;
            wstart_reg  <= wstart_next;
            sum_reg     <= sum_next;
            tgt_st_reg  <= tgt_st_next;
            tgt_exp_reg <= tgt_exp_next;
            tgt_con_reg <= tgt_con_next;
            if (wr_en) begin
                table_reg[q_item.item.entry_index[GI_W-1:0]] <= q_item.item.entry_value;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg.trigger       <= trig;
            out_reg.direction     <= dir_next;
            out_reg.display_value <= disp;
            out_reg.target        <= tgt_out;
            out_reg.gauge_index   <= sel_next;
        end
    end

endmodule

`default_nettype wire

// File: src/gtt_checker.sv
// Port-level checks for the gauge target trigger, bound to the top level.
// Depends on gtt_pkg and gauge_target_trigger.
`default_nettype none

module gtt_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire gtt_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire gtt_pkg::out_item_t m_data
);

    logic [2:0] last_idx_reg;
    logic       seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            last_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            seen_reg     <= 1'b1;
            last_idx_reg <= m_data.gauge_index;
        end
    end

    // A stalled input item must hold until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed or dropped while stalled");

    // A stalled result must hold until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Reset empties the queue and the output register.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not empty after reset");

    // The gauge index moves by at most one step from one result to the next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && seen_reg |->
            (m_data.gauge_index == last_idx_reg) ||
            (m_data.gauge_index == last_idx_reg + 3'd1) ||
            (last_idx_reg == m_data.gauge_index + 3'd1))
        else $error("gauge index jumped by more than one step");

endmodule

bind gauge_target_trigger gtt_checker u_gtt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
